// ===== sv/lpht_pkg.sv =====
// Package for the linear probing hash table: sizes, marks, status and function codes.
// No dependencies; compiled first.
package lpht_pkg;
	localparam int SLOTS     = 256;
	localparam int IDX_W     = $clog2(SLOTS);
	localparam int CNT_W     = $clog2(SLOTS + 1);
	localparam int KEY_BYTES = 8;
	localparam logic [63:0] HASH_START = 64'h1337_1337_dead_beef;

	localparam logic [1:0] MARK_EMPTY = 2'd0;
	localparam logic [1:0] MARK_LIVE  = 2'd1;
	localparam logic [1:0] MARK_TOMB  = 2'd2;

	localparam logic [1:0] FUNC_PUT = 2'd0;
	localparam logic [1:0] FUNC_GET = 2'd1;
	localparam logic [1:0] FUNC_DEL = 2'd2;
	localparam logic [1:0] FUNC_NOP = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NOTFOUND = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;

	typedef struct packed {
		logic [1:0]  func;
		logic [63:0] key;
		logic [63:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [IDX_W-1:0] slot;
		logic [63:0]      found_value;
		logic [CNT_W-1:0] live_count;
	} rsp_t;

	// Keep bytes up to the first zero byte and below KEY_BYTES.
	function automatic logic [63:0] norm_key(input logic [63:0] k);
		logic [63:0] r;
		logic        stop;
		r = '0;
		stop = 1'b0;
		for (int i = 0; i < 8; i++) begin
			if (i >= KEY_BYTES || k[8*i +: 8] == 8'd0) stop = 1'b1;
			if (!stop) r[8*i +: 8] = k[8*i +: 8];
		end
		return r;
	endfunction
endpackage

// ===== sv/lpht_if.sv =====
// Valid/ready channel interfaces for requests and responses.
// Depends on lpht_pkg.
interface lpht_req_if;
	logic          valid;
	logic          ready;
	lpht_pkg::req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface lpht_rsp_if;
	logic          valid;
	logic          ready;
	lpht_pkg::rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== sv/lpht_hash.sv =====
// Byte-serial key hash followed by a restoring modulo by the slot count.
// Depends on lpht_pkg.
module lpht_hash (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [63:0]             key,
	input  logic [lpht_pkg::CNT_W-1:0] n,
	output logic                    done,
	output logic [lpht_pkg::IDX_W-1:0] home
);
	import lpht_pkg::*;

	localparam logic [1:0] H_IDLE = 2'd0;
	localparam logic [1:0] H_HASH = 2'd1;
	localparam logic [1:0] H_MOD  = 2'd2;

	logic [1:0]  state_q;
	logic [63:0] h_q;
	logic [63:0] k_q;
	logic [3:0]  bcnt_q;
	logic [6:0]  bit_q;
	logic [CNT_W:0] rem_q;
	logic [63:0] b_ext;
	logic [CNT_W:0] rem_sh;

	assign b_ext  = {{56{k_q[7]}}, k_q[7:0]};
	assign rem_sh = {rem_q[CNT_W-1:0], h_q[63]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= H_IDLE;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				H_IDLE: begin
					if (start) begin
						state_q <= H_HASH;
						h_q     <= HASH_START;
						k_q     <= key;
						bcnt_q  <= '0;
					end
				end
				H_HASH: begin
					if (k_q[7:0] == 8'd0 || bcnt_q == 4'd8) begin
						state_q <= H_MOD;
						rem_q   <= '0;
						bit_q   <= '0;
					end else begin
						h_q    <= ((h_q ^ b_ext) << 8) + b_ext;
						k_q    <= k_q >> 8;
						bcnt_q <= bcnt_q + 4'd1;
					end
				end
				H_MOD: begin
					// One quotient bit per cycle, most significant first.
					if (rem_sh >= {1'b0, n}) rem_q <= rem_sh - {1'b0, n};
					else rem_q <= rem_sh;
					h_q   <= h_q << 1;
					bit_q <= bit_q + 7'd1;
					if (bit_q == 7'd63) begin
						state_q <= H_IDLE;
						done    <= 1'b1;
					end
				end
				default: state_q <= H_IDLE;
			endcase
		end
	end

	assign home = rem_q[IDX_W-1:0];
endmodule

// ===== sv/lpht_store.sv =====
// Slot storage: mark, key and value memories with registered synchronous reads.
// Marks use per-slot valid bits so reset leaves every slot empty. Depends on lpht_pkg.
module lpht_store (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [lpht_pkg::IDX_W-1:0] raddr,
	output logic [1:0]              rmark,
	output logic [63:0]             rkey,
	output logic [63:0]             rvalue,
	input  logic                    we,
	input  logic [lpht_pkg::IDX_W-1:0] waddr,
	input  logic [1:0]              wmark,
	input  logic [63:0]             wkey,
	input  logic [63:0]             wvalue
);
	import lpht_pkg::*;

	logic [1:0]  mark_mem [SLOTS];
	logic [63:0] key_mem [SLOTS];
	logic [63:0] val_mem [SLOTS];
	logic [SLOTS-1:0] vld_q;
	logic        vld_s1;
	logic [1:0]  mark_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (we) vld_q[waddr] <= 1'b1;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mark_mem[waddr] <= wmark;
			key_mem[waddr]  <= wkey;
			val_mem[waddr]  <= wvalue;
		end
		mark_s1 <= mark_mem[raddr];
		rkey    <= key_mem[raddr];
		rvalue  <= val_mem[raddr];
		vld_s1  <= vld_q[raddr];
	end

	assign rmark = vld_s1 ? mark_s1 : MARK_EMPTY;
endmodule

// ===== sv/linear_probe_hash_table_top.sv =====
// Top level of the linear probing hash table: request control, probe walk, response register.
// Depends on lpht_pkg, lpht_if, lpht_hash and lpht_store.
//
// Channel | dir | fields
// req     | in  | func, key, value
// rsp     | out | status, slot, found_value, live_count
// cfg     | in  | slots_in_use (cfg_we, cfg_wdata)
//
// One request at a time. After a request is accepted, the hash unit walks the key
// one byte per step, then reduces the 64-bit hash modulo the slot count one
// remainder bit per step, most significant first, and hands the home slot over.
// Each slot visited in the probe walk passes through a read state and a check
// state, since each memory read is registered; the final state then writes back
// and forms the response register, which is offered on rsp.
// Reset clears the slot marks at once through per-slot valid bits; no sweep.
// The response waits in its register while rsp.ready is low; the next request
// is accepted once the response has been taken.
module linear_probe_hash_table_top (
	input  logic      clk,
	input  logic      arst_n,
	lpht_req_if.sink   req,
	lpht_rsp_if.source rsp,
	input  logic      cfg_we,
	input  logic [8:0] cfg_wdata
);
	import lpht_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_HASH = 3'd1;
	localparam logic [2:0] S_READ = 3'd2;
	localparam logic [2:0] S_CHK  = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;
	localparam logic [2:0] S_RSP  = 3'd5;

	logic [2:0]       state_q;
	logic [8:0]       cfg_q;
	logic [CNT_W-1:0] n_q;
	logic [CNT_W-1:0] count_q;
	req_t             req_q;
	logic [IDX_W-1:0] idx_q;
	logic [CNT_W-1:0] step_q;
	logic             have_free_q, hit_q;
	logic [IDX_W-1:0] free_q, hit_idx_q;
	logic [63:0]      hit_val_q;
	rsp_t             rsp_q;

	logic             hash_done;
	logic [IDX_W-1:0] home;
	logic [1:0]       rmark;
	logic [63:0]      rkey, rvalue;
	logic             we;
	logic [IDX_W-1:0] waddr;
	logic [1:0]       wmark;
	logic [63:0]      wkey, wvalue;
	logic [CNT_W-1:0] n_eff;
	logic [IDX_W-1:0] idx_next;
	logic             hash_start;
	rsp_t             rsp_next;
	logic [CNT_W-1:0] count_next;

	// Out-of-range slot counts clamp to one and to the table size.
	always_comb begin
		if (cfg_q == 9'd0) n_eff = CNT_W'(1);
		else if ({1'b0, cfg_q} > 10'(SLOTS)) n_eff = CNT_W'(SLOTS);
		else n_eff = CNT_W'(cfg_q);
	end

	assign idx_next   = ({1'b0, idx_q} + 1'b1 == n_q) ? '0 : idx_q + 1'b1;
	assign hash_start = (state_q == S_IDLE) && req.valid;
	assign req.ready  = (state_q == S_IDLE);
	assign rsp.valid  = (state_q == S_RSP);
	assign rsp.data   = rsp_q;

	lpht_hash u_hash (
		.clk, .arst_n,
		.start(hash_start),
		.key(norm_key(req.data.key)),
		.n(n_eff),
		.done(hash_done),
		.home
	);

	lpht_store u_store (
		.clk, .arst_n,
		.raddr(idx_q),
		.rmark, .rkey, .rvalue,
		.we, .waddr, .wmark, .wkey, .wvalue
	);

	// Write-back decision, taken in the final state once the walk has ended.
	always_comb begin
		we     = 1'b0;
		waddr  = hit_idx_q;
		wmark  = MARK_LIVE;
		wkey   = req_q.key;
		wvalue = req_q.value;
		if (state_q == S_DONE) begin
			if (req_q.func == FUNC_PUT) begin
				if (hit_q) we = 1'b1;
				else if (have_free_q) begin
					we    = 1'b1;
					waddr = free_q;
				end
			end else if (req_q.func == FUNC_DEL && hit_q) begin
				we     = 1'b1;
				wmark  = MARK_TOMB;
				wkey   = '0;
				wvalue = '0;
			end
		end
	end

	// Response and live count that the final state registers.
	always_comb begin
		count_next           = count_q;
		rsp_next.status      = ST_NOTFOUND;
		rsp_next.slot        = '0;
		rsp_next.found_value = '0;
		if (req_q.func == FUNC_PUT) begin
			if (hit_q) begin
				rsp_next.status = ST_OK;
				rsp_next.slot   = hit_idx_q;
			end else if (have_free_q) begin
				rsp_next.status = ST_OK;
				rsp_next.slot   = free_q;
				count_next      = count_q + 1'b1;
			end else rsp_next.status = ST_FULL;
		end else if (req_q.func == FUNC_GET && hit_q) begin
			rsp_next.status      = ST_OK;
			rsp_next.slot        = hit_idx_q;
			rsp_next.found_value = hit_val_q;
		end else if (req_q.func == FUNC_DEL && hit_q) begin
			rsp_next.status = ST_OK;
			rsp_next.slot   = hit_idx_q;
			if (count_q != '0) count_next = count_q - 1'b1;
		end
		rsp_next.live_count = count_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cfg_q   <= 9'd256;
			count_q <= '0;
		end else begin
			if (cfg_we) cfg_q <= cfg_wdata;
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						state_q     <= S_HASH;
						req_q       <= '{func: req.data.func, key: norm_key(req.data.key),
							value: req.data.value};
						n_q         <= n_eff;
						have_free_q <= 1'b0;
						hit_q       <= 1'b0;
						step_q      <= '0;
					end
				end
				S_HASH: begin
					if (hash_done) begin
						idx_q   <= home;
						state_q <= (req_q.func == FUNC_NOP) ? S_DONE : S_READ;
					end
				end
				S_READ: state_q <= S_CHK;
				S_CHK: begin
					if (rmark == MARK_LIVE && rkey == req_q.key) begin
						hit_q     <= 1'b1;
						hit_idx_q <= idx_q;
						hit_val_q <= rvalue;
						state_q   <= S_DONE;
					end else begin
						if (rmark != MARK_LIVE && !have_free_q) begin
							have_free_q <= 1'b1;
							free_q      <= idx_q;
						end
						if (rmark == MARK_EMPTY || step_q + 1'b1 == n_q) state_q <= S_DONE;
						else state_q <= S_READ;
						idx_q  <= idx_next;
						step_q <= step_q + 1'b1;
					end
				end
				S_DONE: begin
					state_q <= S_RSP;
					rsp_q   <= rsp_next;
					count_q <= count_next;
				end
				S_RSP: if (rsp.ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== sv/lpht_check.sv =====
// Port-level checker for the hash table top level, bound to it below.
// Depends on lpht_pkg.
module lpht_check (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input lpht_pkg::rsp_t rsp_data
);
	import lpht_pkg::*;

	a_no_req_with_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !req_ready) else $error("request taken while response pending");
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("response dropped or changed");
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_data.status <= ST_FULL) else $error("bad status");
	a_fail_slot: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.status != ST_OK |-> rsp_data.slot == '0 &&
		rsp_data.found_value == '0) else $error("failure with nonzero slot");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_data.live_count <= CNT_W'(SLOTS)) else $error("count overflow");
endmodule

bind linear_probe_hash_table_top lpht_check u_lpht_check (
	.clk(clk), .arst_n(arst_n),
	.req_valid(req.valid), .req_ready(req.ready),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
	.rsp_data(rsp.data)
);
